@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the receive parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/gprx_pkg.sv @@
// ----------------------------------------------------------------------------
// gprx_pkg
// Types and codes shared by the grid protocol receive parser modules.
// ----------------------------------------------------------------------------
package gprx_pkg;

    // Kind of event carried by one result beat.
    typedef enum logic [1:0] {
        EV_GRID_KEY  = 2'd0,
        EV_ENC_DELTA = 2'd1,
        EV_ENC_KEY   = 2'd2,
        EV_STATUS    = 2'd3
    } t_event_kind;

    // Header address nibbles.
    localparam logic [3:0] ADR_SYSTEM = 4'h0;
    localparam logic [3:0] ADR_KEY    = 4'h2;
    localparam logic [3:0] ADR_ENC    = 4'h5;
    localparam logic [3:0] ADR_TILT   = 4'h8;

    // System command nibbles.
    localparam logic [3:0] CMD_SYS_QUERY   = 4'h0;
    localparam logic [3:0] CMD_SYS_ID      = 4'h1;
    localparam logic [3:0] CMD_SYS_OFFSET  = 4'h2;
    localparam logic [3:0] CMD_SYS_SIZE    = 4'h3;
    localparam logic [3:0] CMD_SYS_ADDR    = 4'h4;
    localparam logic [3:0] CMD_SYS_VERSION = 4'hF;

    // Key command nibbles.
    localparam logic [3:0] CMD_KEY_UP   = 4'h0;
    localparam logic [3:0] CMD_KEY_DOWN = 4'h1;

    // Encoder command nibbles.
    localparam logic [3:0] CMD_ENC_DELTA    = 4'h0;
    localparam logic [3:0] CMD_ENC_KEY_UP   = 4'h1;
    localparam logic [3:0] CMD_ENC_KEY_DOWN = 4'h2;

    // Tilt command nibbles.
    localparam logic [3:0] CMD_TILT_ACTIVE = 4'h0;
    localparam logic [3:0] CMD_TILT_DATA   = 4'h1;

    // Padding byte skipped between messages.
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    // Subsystem number reported by encoder devices in a query response.
    localparam logic [7:0] SUBSYS_ENC = 8'h05;

    // One result beat.
    typedef struct packed {
        t_event_kind       kind;
        logic [7:0]        pos_or_number;
        logic [7:0]        row_pos;
        logic              pressed;
        logic signed [7:0] turn_delta;
        logic [4:0]        cols_now;
        logic [4:0]        rows_now;
        logic [2:0]        encoders_now;
        logic              arc_mode;
    } t_result;

endpackage

@@ hw/rtl/grid_protocol_rx_parser.sv @@
// ----------------------------------------------------------------------------
// grid_protocol_rx_parser
// Byte-serial receive parser for a grid and encoder controller link.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Beat contents
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | i_rx_byte, one received byte
//  result  | out       | o_valid / i_stall  | event kind, key/encoder data and
//          |           |                    | the current discovery state
//
// Each byte lands in the input register, from which the framing state and
// decode logic consume it and load any event into the result register, so
// an event passes through both registers after its last byte.
// One byte is taken per cycle for as long as the result side keeps up.
// A beat that produces no event (padding, headers, payload, silent messages)
// still steps the parser but leaves no output beat.
// Reset is synchronous and active low; it returns the parser to idle and
// clears the discovered grid size, encoder count and arc mode.
// When the result register holds a beat that is stalled, the parser waits and
// the input register holds its byte; o_stall rises only when both are full.
//
module grid_protocol_rx_parser #(
    parameter int MAX_COLS     = 16,
    parameter int MAX_ROWS     = 16,
    parameter int MAX_ENCODERS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,

    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_event_kind,
    output logic [7:0]        o_pos_or_number,
    output logic [7:0]        o_row_pos,
    output logic              o_pressed,
    output logic signed [7:0] o_turn_delta,
    output logic [4:0]        o_cols_now,
    output logic [4:0]        o_rows_now,
    output logic [2:0]        o_encoders_now,
    output logic              o_arc_mode
);

`include "assert_macros.svh"

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Result register.
    logic              r_out_valid;
    gprx_pkg::t_result r_out;

    // The parser may step when the result register is empty or being drained.
    logic              w_advance;
    logic              w_fire;
    logic              w_has_result;
    gprx_pkg::t_result w_result;

    assign w_advance = !r_out_valid || !i_stall;
    assign w_fire    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;

    gprx_core #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_ENCODERS (MAX_ENCODERS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_byte       (r_in_byte),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // The input register reloads whenever it is not holding a stalled byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // The result register loads only when the step makes an event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_out.kind;
    assign o_pos_or_number = r_out.pos_or_number;
    assign o_row_pos       = r_out.row_pos;
    assign o_pressed       = r_out.pressed;
    assign o_turn_delta    = r_out.turn_delta;
    assign o_cols_now      = r_out.cols_now;
    assign o_rows_now      = r_out.rows_now;
    assign o_encoders_now  = r_out.encoders_now;
    assign o_arc_mode      = r_out.arc_mode;

    // A fresh result beat must come from a parser step in the cycle before.
    `ASSERT_CLK(a_result_from_step, (o_valid && !$past(o_valid && i_stall)) |-> $past(w_fire), "result beat without a parser step")
    // A byte waiting in the input register is neither lost nor altered.
    `ASSERT_CLK(a_in_hold, (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)), "held input byte changed")
    // Reset leaves both registers empty.
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_in_valid && !r_out_valid), "registers not empty after reset")

endmodule

@@ hw/rtl/gprx_core.sv @@
// ----------------------------------------------------------------------------
// gprx_core
// Message framing state, payload capture and decode for one byte per cycle while i_fire is high.
// ----------------------------------------------------------------------------
module gprx_core #(
    parameter int MAX_COLS     = 16,
    parameter int MAX_ROWS     = 16,
    parameter int MAX_ENCODERS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_has_result,
    output gprx_pkg::t_result o_result
);

    localparam logic [7:0] MaxColsB = 8'(MAX_COLS);
    localparam logic [7:0] MaxRowsB = 8'(MAX_ROWS);
    localparam logic [7:0] MaxEncB  = 8'(MAX_ENCODERS);

    // Total message length in bytes, header included.
    function automatic logic [5:0] f_msg_length(input logic [7:0] hdr);
        logic [3:0] adr;
        logic [3:0] cmd;
        logic [5:0] len;
        adr = hdr[7:4];
        cmd = hdr[3:0];
        len = 6'd1;
        case (adr)
            gprx_pkg::ADR_SYSTEM: begin
                case (cmd)
                    gprx_pkg::CMD_SYS_QUERY:   len = 6'd3;
                    gprx_pkg::CMD_SYS_ID:      len = 6'd33;
                    gprx_pkg::CMD_SYS_OFFSET:  len = 6'd4;
                    gprx_pkg::CMD_SYS_SIZE:    len = 6'd3;
                    gprx_pkg::CMD_SYS_ADDR:    len = 6'd3;
                    gprx_pkg::CMD_SYS_VERSION: len = 6'd9;
                    default:                   len = 6'd1;
                endcase
            end
            gprx_pkg::ADR_KEY: begin
                if (cmd == gprx_pkg::CMD_KEY_UP || cmd == gprx_pkg::CMD_KEY_DOWN) begin
                    len = 6'd3;
                end
            end
            gprx_pkg::ADR_ENC: begin
                if (cmd == gprx_pkg::CMD_ENC_DELTA) begin
                    len = 6'd3;
                end else if (cmd == gprx_pkg::CMD_ENC_KEY_UP ||
                             cmd == gprx_pkg::CMD_ENC_KEY_DOWN) begin
                    len = 6'd2;
                end
            end
            gprx_pkg::ADR_TILT: begin
                if (cmd == gprx_pkg::CMD_TILT_ACTIVE) begin
                    len = 6'd2;
                end else if (cmd == gprx_pkg::CMD_TILT_DATA) begin
                    len = 6'd8;
                end
            end
            default: len = 6'd1;
        endcase
        return len;
    endfunction

    logic [7:0] r_header, n_header;
    logic [5:0] r_needed, n_needed;
    logic [5:0] r_seen,   n_seen;
    logic [7:0] r_p1,     n_p1;
    logic [7:0] r_p2,     n_p2;
    logic [4:0] r_cols,   n_cols;
    logic [4:0] r_rows,   n_rows;
    logic [2:0] r_enc,    n_enc;
    logic       r_arc,    n_arc;

    logic [5:0] w_len;
    logic [5:0] w_seen_inc;
    logic [3:0] w_adr;
    logic [3:0] w_cmd;
    logic [7:0] w_enc_cnt;
    gprx_pkg::t_event_kind w_kind;
    logic [7:0] w_pos;
    logic [7:0] w_row;
    logic       w_pressed;
    logic [7:0] w_delta;

    assign w_len      = f_msg_length(i_byte);
    assign w_seen_inc = r_seen + 6'd1;
    assign w_adr      = r_header[7:4];
    assign w_cmd      = r_header[3:0];
    assign w_enc_cnt  = (n_p2 > MaxEncB) ? MaxEncB : n_p2;

    always_comb begin
        n_header     = r_header;
        n_needed     = r_needed;
        n_seen       = r_seen;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_cols       = r_cols;
        n_rows       = r_rows;
        n_enc        = r_enc;
        n_arc        = r_arc;
        o_has_result = 1'b0;
        w_kind       = gprx_pkg::EV_STATUS;
        w_pos        = 8'd0;
        w_row        = 8'd0;
        w_pressed    = 1'b0;
        w_delta      = 8'd0;

        if (i_fire) begin
            if (r_needed == 6'd0) begin
                // Between messages: padding is dropped, anything else opens a message.
                if (i_byte != gprx_pkg::PAD_BYTE) begin
                    n_header = i_byte;
                    if (w_len <= 6'd1) begin
                        n_seen = 6'd0;
                    end else begin
                        n_needed = w_len;
                        n_seen   = 6'd1;
                    end
                end
            end else begin
                if (r_seen == 6'd1) begin
                    n_p1 = i_byte;
                end else if (r_seen == 6'd2) begin
                    n_p2 = i_byte;
                end
                n_seen = w_seen_inc;

                if (w_seen_inc >= r_needed) begin
                    n_needed = 6'd0;
                    n_seen   = 6'd0;
                    case (w_adr)
                        gprx_pkg::ADR_SYSTEM: begin
                            if (w_cmd == gprx_pkg::CMD_SYS_SIZE) begin
                                if (n_p1 != 8'd0 && n_p1 <= MaxColsB) begin
                                    n_cols = n_p1[4:0];
                                end
                                if (n_p2 != 8'd0 && n_p2 <= MaxRowsB) begin
                                    n_rows = n_p2[4:0];
                                end
                                o_has_result = 1'b1;
                            end else if (w_cmd == gprx_pkg::CMD_SYS_QUERY) begin
                                if (n_p1 == gprx_pkg::SUBSYS_ENC) begin
                                    n_enc = w_enc_cnt[2:0];
                                    if (w_enc_cnt != 8'd0) begin
                                        n_arc = 1'b1;
                                    end
                                end
                                o_has_result = 1'b1;
                            end
                        end
                        gprx_pkg::ADR_KEY: begin
                            if (w_cmd == gprx_pkg::CMD_KEY_UP ||
                                w_cmd == gprx_pkg::CMD_KEY_DOWN) begin
                                o_has_result = 1'b1;
                                w_pos        = n_p1;
                                w_pressed    = (w_cmd == gprx_pkg::CMD_KEY_DOWN);
                                if (r_arc) begin
                                    w_kind = gprx_pkg::EV_ENC_KEY;
                                end else begin
                                    w_kind = gprx_pkg::EV_GRID_KEY;
                                    w_row  = n_p2;
                                end
                            end
                        end
                        gprx_pkg::ADR_ENC: begin
                            w_pos = n_p1;
                            if (w_cmd == gprx_pkg::CMD_ENC_DELTA) begin
                                o_has_result = 1'b1;
                                w_kind       = gprx_pkg::EV_ENC_DELTA;
                                w_delta      = n_p2;
                            end else if (w_cmd == gprx_pkg::CMD_ENC_KEY_UP) begin
                                o_has_result = 1'b1;
                                w_kind       = gprx_pkg::EV_ENC_KEY;
                            end else if (w_cmd == gprx_pkg::CMD_ENC_KEY_DOWN) begin
                                o_has_result = 1'b1;
                                w_kind       = gprx_pkg::EV_ENC_KEY;
                                w_pressed    = 1'b1;
                            end
                        end
                        default: begin
                            o_has_result = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // The discovery fields show the state as it stands after this byte.
    always_comb begin
        o_result.kind          = w_kind;
        o_result.pos_or_number = w_pos;
        o_result.row_pos       = w_row;
        o_result.pressed       = w_pressed;
        o_result.turn_delta    = $signed(w_delta);
        o_result.cols_now      = n_cols;
        o_result.rows_now      = n_rows;
        o_result.encoders_now  = n_enc;
        o_result.arc_mode      = n_arc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 8'd0;
            r_needed <= 6'd0;
            r_seen   <= 6'd0;
            r_p1     <= 8'd0;
            r_p2     <= 8'd0;
            r_cols   <= 5'd0;
            r_rows   <= 5'd0;
            r_enc    <= 3'd0;
            r_arc    <= 1'b0;
        end else begin
            r_header <= n_header;
            r_needed <= n_needed;
            r_seen   <= n_seen;
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_cols   <= n_cols;
            r_rows   <= n_rows;
            r_enc    <= n_enc;
            r_arc    <= n_arc;
        end
    end

endmodule

@@ tb/grid_protocol_rx_parser_checker.sv @@
// ----------------------------------------------------------------------------
// grid_protocol_rx_parser_checker
// Watches both channels of the receive parser, predicts the event beats from
// the accepted bytes and compares every delivered beat field by field.
// ----------------------------------------------------------------------------
module grid_protocol_rx_parser_checker #(
    parameter int MAX_COLS     = 16,
    parameter int MAX_ROWS     = 16,
    parameter int MAX_ENCODERS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_byte_valid,
    input  logic              i_byte_stall,
    input  logic [7:0]        i_rx_byte,

    input  logic              i_ev_valid,
    input  logic              i_ev_stall,
    input  logic [1:0]        i_event_kind,
    input  logic [7:0]        i_pos_or_number,
    input  logic [7:0]        i_row_pos,
    input  logic              i_pressed,
    input  logic signed [7:0] i_turn_delta,
    input  logic [4:0]        i_cols_now,
    input  logic [4:0]        i_rows_now,
    input  logic [2:0]        i_encoders_now,
    input  logic              i_arc_mode,

    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    import gprx_pkg::*;

    localparam int MAX_REPORTS = 30;

    // Framing state and discovery state of the predicted parser.
    logic [7:0] frame_hdr;
    logic [5:0] frame_need;
    logic [5:0] frame_seen;
    logic [7:0] pay_first;
    logic [7:0] pay_second;
    logic [4:0] grid_cols;
    logic [4:0] grid_rows;
    logic [2:0] enc_count;
    logic       arc_seen;

    t_result    pending_events[$];
    int         fail_count;
    int         checked_count;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;

    initial begin
        fail_count    = 0;
        checked_count = 0;
        o_pending     = 0;
    end

    function automatic logic [5:0] frame_length(input logic [7:0] hdr);
        logic [5:0] len;
        len = 6'd1;
        case (hdr[7:4])
            ADR_SYSTEM: begin
                case (hdr[3:0])
                    CMD_SYS_QUERY:   len = 6'd3;
                    CMD_SYS_ID:      len = 6'd33;
                    CMD_SYS_OFFSET:  len = 6'd4;
                    CMD_SYS_SIZE:    len = 6'd3;
                    CMD_SYS_ADDR:    len = 6'd3;
                    CMD_SYS_VERSION: len = 6'd9;
                    default:         len = 6'd1;
                endcase
            end
            ADR_KEY: begin
                if (hdr[3:0] == CMD_KEY_UP || hdr[3:0] == CMD_KEY_DOWN) len = 6'd3;
            end
            ADR_ENC: begin
                if (hdr[3:0] == CMD_ENC_DELTA) len = 6'd3;
                else if (hdr[3:0] == CMD_ENC_KEY_UP || hdr[3:0] == CMD_ENC_KEY_DOWN)
                    len = 6'd2;
            end
            ADR_TILT: begin
                if (hdr[3:0] == CMD_TILT_ACTIVE) len = 6'd2;
                else if (hdr[3:0] == CMD_TILT_DATA) len = 6'd8;
            end
            default: len = 6'd1;
        endcase
        return len;
    endfunction

    // A complete frame updates the discovery state first; the event then
    // carries the state as it stands after the update.
    task automatic decode_frame;
        t_result    ev;
        bit         emit;
        int         enc_total;
        logic [3:0] adr;
        logic [3:0] cmd;
        adr  = frame_hdr[7:4];
        cmd  = frame_hdr[3:0];
        ev   = '0;
        emit = 1'b0;
        case (adr)
            ADR_SYSTEM: begin
                if (cmd == CMD_SYS_SIZE) begin
                    if (pay_first > 0 && pay_first <= MAX_COLS) grid_cols = pay_first[4:0];
                    if (pay_second > 0 && pay_second <= MAX_ROWS) grid_rows = pay_second[4:0];
                    ev.kind = EV_STATUS;
                    emit    = 1'b1;
                end else if (cmd == CMD_SYS_QUERY) begin
                    if (pay_first == SUBSYS_ENC) begin
                        enc_total = (pay_second > MAX_ENCODERS) ? MAX_ENCODERS : pay_second;
                        enc_count = enc_total[2:0];
                        if (enc_total > 0) arc_seen = 1'b1;
                    end
                    ev.kind = EV_STATUS;
                    emit    = 1'b1;
                end
            end
            ADR_KEY: begin
                if (cmd == CMD_KEY_UP || cmd == CMD_KEY_DOWN) begin
                    ev.kind          = arc_seen ? EV_ENC_KEY : EV_GRID_KEY;
                    ev.pos_or_number = pay_first;
                    ev.row_pos       = arc_seen ? 8'd0 : pay_second;
                    ev.pressed       = (cmd == CMD_KEY_DOWN);
                    emit             = 1'b1;
                end
            end
            ADR_ENC: begin
                ev.pos_or_number = pay_first;
                emit             = 1'b1;
                if (cmd == CMD_ENC_DELTA) begin
                    ev.kind       = EV_ENC_DELTA;
                    ev.turn_delta = pay_second;
                end else if (cmd == CMD_ENC_KEY_UP) begin
                    ev.kind = EV_ENC_KEY;
                end else if (cmd == CMD_ENC_KEY_DOWN) begin
                    ev.kind    = EV_ENC_KEY;
                    ev.pressed = 1'b1;
                end else begin
                    emit = 1'b0;
                end
            end
            default: ;
        endcase
        if (emit) begin
            ev.cols_now     = grid_cols;
            ev.rows_now     = grid_rows;
            ev.encoders_now = enc_count;
            ev.arc_mode     = arc_seen;
            pending_events.push_back(ev);
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [5:0] len;
        if (frame_need == 6'd0) begin
            // Padding is only skipped between frames.
            if (b != PAD_BYTE) begin
                frame_hdr = b;
                len       = frame_length(b);
                if (len <= 6'd1) begin
                    frame_seen = 6'd0;
                end else begin
                    frame_need = len;
                    frame_seen = 6'd1;
                end
            end
        end else begin
            if (frame_seen == 6'd1) pay_first = b;
            else if (frame_seen == 6'd2) pay_second = b;
            frame_seen = frame_seen + 6'd1;
            if (frame_seen >= frame_need) begin
                decode_frame();
                frame_need = 6'd0;
                frame_seen = 6'd0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] event mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("beat %0d %s is %0d, expected %0d",
                                      checked_count, field, got, want));
    endtask

    task automatic check_event;
        t_result want;
        checked_count++;
        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", checked_count));
        end else begin
            want = pending_events.pop_front();
            compare_field("event_kind", i_event_kind, want.kind);
            compare_field("pos_or_number", i_pos_or_number, want.pos_or_number);
            compare_field("row_pos", i_row_pos, want.row_pos);
            compare_field("pressed", i_pressed, want.pressed);
            compare_field("turn_delta", $signed(i_turn_delta), $signed(want.turn_delta));
            compare_field("cols_now", i_cols_now, want.cols_now);
            compare_field("rows_now", i_rows_now, want.rows_now);
            compare_field("encoders_now", i_encoders_now, want.encoders_now);
            compare_field("arc_mode", i_arc_mode, want.arc_mode);
        end
    endtask

    // The output side is checked before the input side so that a beat never
    // meets an expectation pushed at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_hdr  = 8'd0;
            frame_need = 6'd0;
            frame_seen = 6'd0;
            pay_first  = 8'd0;
            pay_second = 8'd0;
            grid_cols  = 5'd0;
            grid_rows  = 5'd0;
            enc_count  = 3'd0;
            arc_seen   = 1'b0;
            pending_events.delete();
            o_pending <= 0;
        end else begin
            if (i_ev_valid && !i_ev_stall) check_event();
            if (i_byte_valid && !i_byte_stall) absorb_byte(i_rx_byte);
            o_pending <= pending_events.size();
        end
    end

endmodule

@@ tb/grid_protocol_rx_parser_tb.sv @@
// ----------------------------------------------------------------------------
// grid_protocol_rx_parser_tb
// Drives the receive parser with directed frames and then with random frame
// streams under three idle patterns; a checker beside the block predicts and
// compares every event beat.
// ----------------------------------------------------------------------------
module grid_protocol_rx_parser_tb;

    import gprx_pkg::*;

    localparam int MAX_COLS       = 16;
    localparam int MAX_ROWS       = 16;
    localparam int MAX_ENCODERS   = 4;

    // An event passes through the input and result registers after the last byte
    // of a frame, so a short tail is enough to catch any stray beat after the last one.
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Byte counts at which each random phase stops.
    localparam int PHASE1_BYTES   = 520;
    localparam int PHASE2_BYTES   = 1040;
    localparam int PHASE3_BYTES   = 1550;

    // A key command above key down has no frame behind it: one byte only.
    localparam logic [3:0] CMD_KEY_UNUSED = 4'h7;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;

    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [7:0]        in_byte   = 8'd0;

    logic              ev_valid;
    logic              ev_stall  = 1'b0;
    logic [1:0]        ev_kind;
    logic [7:0]        ev_pos;
    logic [7:0]        ev_row;
    logic              ev_pressed;
    logic signed [7:0] ev_delta;
    logic [4:0]        ev_cols;
    logic [4:0]        ev_rows;
    logic [2:0]        ev_encoders;
    logic              ev_arc;

    int                fail_count;
    int                events_pending;
    int                events_checked;

    // Idle percentages for the sending and the receiving side.
    int                src_idle_pct  = 22;
    int                sink_idle_pct = 72;

    // Stimulus bookkeeping for the summary.
    int                bytes_sent     = 0;
    int                key_frames     = 0;
    int                enc_frames     = 0;
    int                disc_frames    = 0;
    int                silent_frames  = 0;
    int                noise_items    = 0;

    grid_protocol_rx_parser #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_ENCODERS (MAX_ENCODERS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_rx_byte       (in_byte),
        .o_valid         (ev_valid),
        .i_stall         (ev_stall),
        .o_event_kind    (ev_kind),
        .o_pos_or_number (ev_pos),
        .o_row_pos       (ev_row),
        .o_pressed       (ev_pressed),
        .o_turn_delta    (ev_delta),
        .o_cols_now      (ev_cols),
        .o_rows_now      (ev_rows),
        .o_encoders_now  (ev_encoders),
        .o_arc_mode      (ev_arc)
    );

    grid_protocol_rx_parser_checker #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_ENCODERS (MAX_ENCODERS)
    ) u_event_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_byte_valid    (in_valid),
        .i_byte_stall    (in_stall),
        .i_rx_byte       (in_byte),
        .i_ev_valid      (ev_valid),
        .i_ev_stall      (ev_stall),
        .i_event_kind    (ev_kind),
        .i_pos_or_number (ev_pos),
        .i_row_pos       (ev_row),
        .i_pressed       (ev_pressed),
        .i_turn_delta    (ev_delta),
        .i_cols_now      (ev_cols),
        .i_rows_now      (ev_rows),
        .i_encoders_now  (ev_encoders),
        .i_arc_mode      (ev_arc),
        .o_fail_count    (fail_count),
        .o_pending       (events_pending),
        .o_checked       (events_checked)
    );

    // 20 time unit clock, first rising edge at 10.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls at random, independent of whether a beat is offered.
    always @(posedge clk) begin
        ev_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end

    // Mostly small values so that sizes and coordinates land near the limits
    // that matter, with a quarter drawn from the whole byte range.
    function automatic logic [7:0] pick_byte(input int hi);
        logic [7:0] v;
        if ($urandom_range(0, 3) == 0) v = 8'($urandom);
        else v = 8'($urandom_range(0, hi));
        return v;
    endfunction

    // Offers one byte, after a random number of idle cycles, and returns in
    // the time step of the edge that accepted it. The byte is held while the
    // parser stalls.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Holds the sender back until every predicted event has been delivered.
    task automatic wait_for_events;
        in_valid <= 1'b0;
        @(posedge clk);
        while (events_pending != 0) @(posedge clk);
    endtask

    // One random item of the stream: most are well-formed frames with random
    // payload; the rest are stray bytes, which may be one-byte headers or may
    // open a frame that swallows whatever follows, and runs of padding.
    // Until arc mode is allowed, encoder query responses report no encoders
    // so that grid key events stay reachable.
    task automatic send_random_frame(input bit allow_arc);
        logic [7:0] frame[$];
        logic [7:0] subsys;
        logic [7:0] count;
        logic [3:0] cmd;
        int         pick;
        int         n_extra;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            frame.push_back({ADR_KEY, $urandom_range(0, 1) ? CMD_KEY_DOWN : CMD_KEY_UP});
            frame.push_back(pick_byte(15));
            frame.push_back(pick_byte(15));
            key_frames++;
        end else if (pick < 60) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                frame.push_back({ADR_ENC, CMD_ENC_DELTA});
                frame.push_back(pick_byte(3));
                frame.push_back(pick_byte(255));
            end else begin
                frame.push_back({ADR_ENC, (pick == 1) ? CMD_ENC_KEY_UP : CMD_ENC_KEY_DOWN});
                frame.push_back(pick_byte(3));
            end
            enc_frames++;
        end else if (pick < 67) begin
            frame.push_back({ADR_SYSTEM, CMD_SYS_SIZE});
            frame.push_back(pick_byte(17));
            frame.push_back(pick_byte(17));
            disc_frames++;
        end else if (pick < 74) begin
            subsys = $urandom_range(0, 1) ? SUBSYS_ENC : pick_byte(8);
            count  = pick_byte(6);
            if (!allow_arc && subsys == SUBSYS_ENC) count = 8'd0;
            frame.push_back({ADR_SYSTEM, CMD_SYS_QUERY});
            frame.push_back(subsys);
            frame.push_back(count);
            disc_frames++;
        end else if (pick < 80) begin
            // The long identity frame is kept rare.
            pick    = $urandom_range(0, 9);
            cmd     = (pick == 0) ? CMD_SYS_ID :
                      (pick < 4)  ? CMD_SYS_OFFSET :
                      (pick < 7)  ? CMD_SYS_ADDR : CMD_SYS_VERSION;
            n_extra = (cmd == CMD_SYS_ID)     ? 32 :
                      (cmd == CMD_SYS_OFFSET) ? 3  :
                      (cmd == CMD_SYS_ADDR)   ? 2  : 8;
            frame.push_back({ADR_SYSTEM, cmd});
            repeat (n_extra) frame.push_back(pick_byte(255));
            silent_frames++;
        end else if (pick < 86) begin
            cmd     = $urandom_range(0, 1) ? CMD_TILT_DATA : CMD_TILT_ACTIVE;
            n_extra = (cmd == CMD_TILT_DATA) ? 7 : 1;
            frame.push_back({ADR_TILT, cmd});
            repeat (n_extra) frame.push_back(pick_byte(255));
            silent_frames++;
        end else if (pick < 94) begin
            frame.push_back(pick_byte(255));
            noise_items++;
        end else begin
            repeat ($urandom_range(1, 4)) frame.push_back(PAD_BYTE);
            noise_items++;
        end
        foreach (frame[k]) send_byte(frame[k]);
    endtask

    // Run-away guard: ends the run when neither channel has moved a beat for
    // too long, which also catches events that never arrive.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (ev_valid && !ev_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Timeout: no beat moved on either channel for %0d cycles.", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, with the sender idling lightly and the receiver
        // stalling heavily. Padding while idle is skipped, and a key header
        // with an unused command is consumed alone.
        send_byte(PAD_BYTE);
        send_byte({ADR_KEY, CMD_KEY_UNUSED});
        // Grid key down at the far corner; the padding value inside a frame
        // is payload, not skipped.
        send_byte({ADR_KEY, CMD_KEY_DOWN}); send_byte(PAD_BYTE); send_byte(8'h00);
        send_byte({ADR_KEY, CMD_KEY_UP});   send_byte(8'h00);    send_byte(PAD_BYTE);
        // Grid size: the largest column count is taken, a row count one
        // beyond the limit is not; then a zero column count is refused while
        // a single row is taken.
        send_byte({ADR_SYSTEM, CMD_SYS_SIZE}); send_byte(8'd16); send_byte(8'd17);
        send_byte({ADR_SYSTEM, CMD_SYS_SIZE}); send_byte(8'd0);  send_byte(8'd1);
        // Encoder delta at the most negative value, then encoder keys.
        send_byte({ADR_ENC, CMD_ENC_DELTA});    send_byte(8'd7); send_byte(8'h80);
        send_byte({ADR_ENC, CMD_ENC_KEY_UP});   send_byte(8'd3);
        send_byte({ADR_ENC, CMD_ENC_KEY_DOWN}); send_byte(8'hFE);
        // Tilt frames complete silently; a query for another subsystem only
        // reports the unchanged status.
        send_byte({ADR_TILT, CMD_TILT_ACTIVE}); send_byte(8'h01);
        send_byte({ADR_SYSTEM, CMD_SYS_QUERY}); send_byte(8'h02); send_byte(8'h09);

        while (bytes_sent < PHASE1_BYTES) send_random_frame(1'b0);

        // The sender holds off until every event is out, then the idle
        // pattern flips: a slow sender against a mostly ready receiver.
        wait_for_events();
        src_idle_pct  = 72;
        sink_idle_pct = 22;
        while (bytes_sent < PHASE2_BYTES) send_random_frame(1'b0);

        wait_for_events();
        src_idle_pct  = 0;
        sink_idle_pct = 0;

        // Arc mode: an encoder count far above the maximum is clamped and
        // turns key frames into encoder key events. A later report of zero
        // encoders clears the count but arc mode stays.
        send_byte({ADR_SYSTEM, CMD_SYS_QUERY}); send_byte(SUBSYS_ENC); send_byte(8'hFF);
        send_byte({ADR_KEY, CMD_KEY_UP});       send_byte(8'd5);       send_byte(8'd6);
        send_byte({ADR_SYSTEM, CMD_SYS_QUERY}); send_byte(SUBSYS_ENC); send_byte(8'h00);
        send_byte({ADR_KEY, CMD_KEY_DOWN});     send_byte(8'd15);      send_byte(8'd15);

        while (bytes_sent < PHASE3_BYTES) send_random_frame(1'b1);

        wait_for_events();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d key, %0d encoder, %0d discovery, %0d silent frames, %0d stray items.",
                 bytes_sent, key_frames, enc_frames, disc_frames, silent_frames, noise_items);
        $display("Checked %0d event beats across three idle patterns; %0d mismatches.",
                 events_checked, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
